@@ hdl/lpf_pkg.sv @@
// Shared constants and types of the length-prefixed ring FIFO.
`default_nettype none

package lpf_pkg;

  localparam int unsigned HEADER_BYTES   = 1;
  localparam int unsigned MAX_ELEM_BYTES = 8;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned FREE_OUT_W = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DATA_BYTES = DATA_W / BYTE_W;
  localparam int unsigned BSEL_W     = $clog2(DATA_BYTES);

  // Wide enough for a byte index within one element and for header plus data.
  localparam int unsigned IDX_W = $clog2(HEADER_BYTES + MAX_ELEM_BYTES + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

endpackage

`default_nettype wire

@@ hdl/lpf_if.sv @@
// Request and response channel interfaces of the length-prefixed ring FIFO.
`default_nettype none

interface lpf_in_if;
  import lpf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [DATA_W-1:0]    elem_data;
  logic [LEN_W-1:0]     elem_len;

  modport source (output valid, kind, elem_data, elem_len, input ready);
  modport sink   (input valid, kind, elem_data, elem_len, output ready);
endinterface

interface lpf_out_if;
  import lpf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [DATA_W-1:0]     out_data;
  logic [LEN_W-1:0]      copied_len;
  logic [LEN_W-1:0]      stored_len;
  logic                  is_empty;
  logic                  would_fit;
  logic [FREE_OUT_W-1:0] free_bytes;

  modport source (output valid, ok, out_data, copied_len, stored_len, is_empty,
                  would_fit, free_bytes, input ready);
  modport sink   (input valid, ok, out_data, copied_len, stored_len, is_empty,
                  would_fit, free_bytes, output ready);
endinterface

`default_nettype wire

@@ hdl/lpf_ram.sv @@
// Byte-wide single-port ring memory with a registered read.
`default_nettype none

module lpf_ram
  import lpf_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/lpf_ctrl.sv @@
// Sequencer: walks header and data bytes through the ring memory and keeps the pointers.
`default_nettype none

module lpf_ctrl
  import lpf_pkg::*;
#(
  parameter int unsigned RING_BYTES = 256,
  localparam int unsigned PtrW      = $clog2(RING_BYTES),
  localparam int unsigned FreeW     = $clog2(RING_BYTES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lpf_in_if.sink                 req_i,
  lpf_out_if.source              rsp_o,
  output logic                   ram_we_o,
  output logic      [PtrW-1:0]   ram_addr_o,
  output logic      [BYTE_W-1:0] ram_wdata_o,
  input  wire logic [BYTE_W-1:0] ram_rdata_i
);

  localparam int unsigned SumW = FreeW + 1;
  localparam logic [IDX_W-1:0] HdrIdx = IDX_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_ELEM_BYTES);
  localparam logic [FreeW-1:0] RingFree = FreeW'(RING_BYTES);
  localparam logic [PtrW-1:0]  LastAddr = PtrW'(RING_BYTES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [KIND_W-1:0]   kind_q;
  logic [DATA_W-1:0]   data_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    cap_q;
  logic                succ_q;
  logic [IDX_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    total_q;
  logic [PtrW-1:0]     addr_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [BYTE_W-1:0]   hdr_q;
  logic                hdr_big_q;
  logic [DATA_W-1:0]   rdat_q;
  logic [PtrW-1:0]     rptr_q;
  logic [PtrW-1:0]     wptr_q;
  logic [FreeW-1:0]    free_q;

  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [DATA_W-1:0]     out_data_q;
  logic [LEN_W-1:0]      out_copied_q;
  logic [LEN_W-1:0]      out_stored_q;
  logic                  out_empty_q;
  logic                  out_fit_q;
  logic [FREE_OUT_W-1:0] out_free_q;

  // Steps a ring address forward by a small amount, one wrap at most.
  function automatic logic [PtrW-1:0] ring_add(logic [PtrW-1:0] ptr, logic [IDX_W-1:0] amt);
    logic [PtrW:0] sum;
    sum = (PtrW+1)'(ptr) + (PtrW+1)'(amt);
    if (sum >= (PtrW+1)'(RING_BYTES)) begin
      sum = sum - (PtrW+1)'(RING_BYTES);
    end
    return sum[PtrW-1:0];
  endfunction

  logic              in_accept;
  logic              in_fits;
  logic [LEN_W-1:0]  in_cap;
  logic              in_is_rd;
  logic [PtrW-1:0]   addr_next;
  logic [BSEL_W-1:0] wr_bsel;
  logic [BYTE_W-1:0] wr_byte;
  logic              rd_issue;
  logic [IDX_W-1:0]  rd_didx;

  logic [LEN_W-1:0]  slen;
  logic [LEN_W-1:0]  ncopy;
  logic [IDX_W-1:0]  take;
  logic [FreeW-1:0]  room;
  logic [DATA_W-1:0] masked;
  logic              is_rd_kind;
  logic              ok_fin;
  logic [PtrW-1:0]   rptr_new;
  logic [PtrW-1:0]   wptr_new;
  logic [FreeW-1:0]  free_new;
  logic              fit_new;
  logic [FreeW+FREE_OUT_W-1:0] free_wide;
  logic              out_load;

  assign in_accept = req_i.valid && req_i.ready;
  assign in_fits   = (req_i.elem_len <= MaxLen) &&
                     (SumW'(req_i.elem_len) + SumW'(HEADER_BYTES) <= SumW'(free_q));
  assign in_cap    = (req_i.elem_len > MaxLen) ? MaxLen : req_i.elem_len;
  assign in_is_rd  = (req_i.kind == KIND_POP) || (req_i.kind == KIND_PEEK);
  assign addr_next = (addr_q == LastAddr) ? '0 : addr_q + PtrW'(1);

  // Header bytes carry the length little-endian; the length fits in the lowest byte.
  assign wr_bsel = BSEL_W'(cnt_q - HdrIdx);
  always_comb begin
    if (cnt_q < HdrIdx) begin
      wr_byte = (cnt_q == '0) ? BYTE_W'(len_q) : '0;
    end else begin
      wr_byte = data_q[wr_bsel*BYTE_W +: BYTE_W];
    end
  end

  assign rd_issue = (state_q == ST_READ) && (cnt_q < total_q);
  assign rd_didx  = rd_idx_q - HdrIdx;

  assign ram_we_o    = (state_q == ST_WRITE);
  assign ram_addr_o  = addr_q;
  assign ram_wdata_o = wr_byte;

  // Result and pointer updates of the finishing cycle.
  always_comb begin
    slen = hdr_big_q ? MaxLen : ((hdr_q > BYTE_W'(MaxLen)) ? MaxLen : LEN_W'(hdr_q));
    ncopy = (slen < cap_q) ? slen : cap_q;
    take  = IDX_W'(slen) + HdrIdx;
    room  = RingFree - free_q;
    for (int b = 0; b < DATA_BYTES; b++) begin
      masked[b*BYTE_W +: BYTE_W] = (LEN_W'(b) < ncopy) ? rdat_q[b*BYTE_W +: BYTE_W] : '0;
    end
    is_rd_kind = (kind_q == KIND_POP) || (kind_q == KIND_PEEK);
    rptr_new = rptr_q;
    wptr_new = wptr_q;
    free_new = free_q;
    ok_fin   = 1'b0;
    case (kind_q)
      KIND_PUSH: begin
        ok_fin = succ_q;
        if (succ_q) begin
          wptr_new = ring_add(wptr_q, IDX_W'(len_q) + HdrIdx);
          free_new = free_q - FreeW'(len_q) - FreeW'(HEADER_BYTES);
        end
      end
      KIND_POP: begin
        ok_fin = succ_q;
        if (succ_q) begin
          rptr_new = ring_add(rptr_q, take);
          free_new = (FreeW'(take) >= room) ? RingFree : free_q + FreeW'(take);
        end
      end
      KIND_PEEK: begin
        ok_fin = succ_q;
      end
      KIND_CLEAR: begin
        ok_fin   = 1'b1;
        rptr_new = '0;
        wptr_new = '0;
        free_new = RingFree;
      end
      KIND_STATUS: begin
        ok_fin = 1'b1;
      end
      default: begin
        ok_fin = 1'b0;
      end
    endcase
    fit_new   = (len_q <= MaxLen) && (SumW'(len_q) + SumW'(HEADER_BYTES) <= SumW'(free_new));
    free_wide = (FreeW+FREE_OUT_W)'(free_new);
  end

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= '0;
      data_q       <= '0;
      len_q        <= '0;
      cap_q        <= '0;
      succ_q       <= 1'b0;
      cnt_q        <= '0;
      total_q      <= '0;
      addr_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      hdr_q        <= '0;
      hdr_big_q    <= 1'b0;
      rdat_q       <= '0;
      rptr_q       <= '0;
      wptr_q       <= '0;
      free_q       <= RingFree;
      out_valid_q  <= 1'b0;
      out_ok_q     <= 1'b0;
      out_data_q   <= '0;
      out_copied_q <= '0;
      out_stored_q <= '0;
      out_empty_q  <= 1'b0;
      out_fit_q    <= 1'b0;
      out_free_q   <= '0;
    end else begin
      // A beat leaving in the same cycle as a new one loads is replaced, not cleared.
      if (rsp_o.valid && rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= rd_issue;
      rd_idx_q <= cnt_q;
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            kind_q    <= req_i.kind;
            data_q    <= req_i.elem_data;
            len_q     <= req_i.elem_len;
            cap_q     <= in_cap;
            cnt_q     <= '0;
            hdr_q     <= '0;
            hdr_big_q <= 1'b0;
            rdat_q    <= '0;
            if (req_i.kind == KIND_PUSH) begin
              succ_q  <= in_fits;
              total_q <= IDX_W'(req_i.elem_len) + HdrIdx;
              addr_q  <= wptr_q;
              state_q <= in_fits ? ST_WRITE : ST_FINISH;
            end else if (in_is_rd) begin
              succ_q  <= (free_q != RingFree);
              total_q <= IDX_W'(in_cap) + HdrIdx;
              addr_q  <= rptr_q;
              state_q <= (free_q != RingFree) ? ST_READ : ST_FINISH;
            end else begin
              succ_q  <= 1'b0;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_WRITE: begin
          addr_q <= addr_next;
          cnt_q  <= cnt_q + IDX_W'(1);
          if (cnt_q == total_q - IDX_W'(1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_READ: begin
          // Reads are issued back to back; each byte lands in the cycle after its read is issued.
          if (rd_issue) begin
            addr_q <= addr_next;
            cnt_q  <= cnt_q + IDX_W'(1);
          end
          if (rd_vld_q) begin
            if (rd_idx_q < HdrIdx) begin
              if (rd_idx_q == '0) begin
                hdr_q <= ram_rdata_i;
              end else if (ram_rdata_i != '0) begin
                hdr_big_q <= 1'b1;
              end
            end else begin
              rdat_q[BSEL_W'(rd_didx)*BYTE_W +: BYTE_W] <= ram_rdata_i;
            end
            if (rd_idx_q == total_q - IDX_W'(1)) begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            rptr_q       <= rptr_new;
            wptr_q       <= wptr_new;
            free_q       <= free_new;
            out_valid_q  <= 1'b1;
            out_ok_q     <= ok_fin;
            out_data_q   <= (succ_q && is_rd_kind) ? masked : '0;
            out_copied_q <= (succ_q && is_rd_kind) ? ncopy : '0;
            out_stored_q <= (succ_q && is_rd_kind) ? slen : '0;
            out_empty_q  <= (free_new == RingFree);
            out_fit_q    <= fit_new;
            out_free_q   <= free_wide[FREE_OUT_W-1:0];
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = out_ok_q;
  assign rsp_o.out_data   = out_data_q;
  assign rsp_o.copied_len = out_copied_q;
  assign rsp_o.stored_len = out_stored_q;
  assign rsp_o.is_empty   = out_empty_q;
  assign rsp_o.would_fit  = out_fit_q;
  assign rsp_o.free_bytes = out_free_q;

endmodule

`default_nettype wire

@@ hdl/length_prefixed_ring_fifo.sv @@
// Top level of the length-prefixed ring FIFO: sequencer plus byte ring memory.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   req_i    | in  | kind, elem_data, elem_len
//   rsp_o    | out | ok, out_data, copied_len, stored_len, is_empty,
//            |     | would_fit, free_bytes
//
// One request is handled at a time. An accepted push writes HEADER_BYTES + len bytes
// in the write state, a pop or peek of a nonempty ring reads HEADER_BYTES + min(capacity, 8)
// bytes in the read state, and anything else, refusals included, goes straight to the
// finishing state; the single byte port of the ring memory sets the pace of these steps.
// The response sits in an output register, so a new request is taken while it waits;
// a stalled response holds the sequencer in its finishing cycle.
// Reset empties the ring at once; the memory contents are not cleared.
`default_nettype none

module length_prefixed_ring_fifo
  import lpf_pkg::*;
#(
  parameter int unsigned RING_BYTES = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lpf_in_if.sink    req_i,
  lpf_out_if.source rsp_o
);

  localparam int unsigned PtrW = $clog2(RING_BYTES);

  logic              ram_we;
  logic [PtrW-1:0]   ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  lpf_ctrl #(
    .RING_BYTES (RING_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  lpf_ram #(
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
